[design/ptc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int PID_W       = 22;
  localparam int VALUE_W     = 64;
  localparam int TICK_W      = 32;
  localparam int TTL_W       = 31;
  localparam int COUNT_OUT_W = 7;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(1000);

  typedef struct packed {
    logic               valid;
    logic [PID_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [TICK_W-1:0]  stamp;
  } entry_t;

  // True when tick a lies strictly before tick b, modulo 2^32.
  function automatic logic tick_before(input logic [TICK_W-1:0] a,
                                       input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] diff;
    diff = a - b;
    return diff[TICK_W-1];
  endfunction

endpackage

`default_nettype wire

[design/ptc_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptc_mem #(
  parameter int ENTRIES = ptc_pkg::ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IW-1:0]   waddr,
  input  wire ptc_pkg::entry_t wdata,
  input  wire logic [IW-1:0]   raddr,
  output ptc_pkg::entry_t      rdata
);

  ptc_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/pid_ttl_cache.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Handshake            | Payload
// -----------+----------------------+----------------------------------------
// command    | start, busy          | operation, pid, value_in, now
// result     | done (one-cycle)     | found, value_out, entry_count
// ttl config | ttl_wr_en            | ttl_wr_data
//
// A command is taken on a clock edge with start high and busy low.
// A command with a nonzero pid scans every slot of the table memory, one read
// per cycle, and busy stays high until its result is returned.
// A command with pid zero returns its result on the next cycle and never
// raises busy. After reset the table is cleared one slot a cycle, and busy
// stays high until every slot is cleared, so no command is taken before that.
// The result receiver cannot stall; done marks each result for one cycle.

module pid_ttl_cache #(
  parameter int ENTRIES = ptc_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            operation,
  input  wire logic [ptc_pkg::PID_W-1:0]       pid,
  input  wire logic [ptc_pkg::VALUE_W-1:0]     value_in,
  input  wire logic [ptc_pkg::TICK_W-1:0]      now,
  output logic                                 done,
  output logic                                 found,
  output logic [ptc_pkg::VALUE_W-1:0]          value_out,
  output logic [ptc_pkg::COUNT_OUT_W-1:0]      entry_count,
  input  wire logic                            ttl_wr_en,
  input  wire logic [ptc_pkg::TTL_W-1:0]       ttl_wr_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [IW:0]   ISSUE_END = (IW + 1)'(ENTRIES);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  logic [ptc_pkg::TTL_W-1:0]   ttl;
  logic [CW-1:0]               count;
  logic [IW-1:0]               clr_idx;
  logic [IW:0]                 iss_cnt;
  logic                        rd_vld;
  logic [IW-1:0]               rd_idx;

  // Latched command.
  logic                        cur_op;
  logic [ptc_pkg::PID_W-1:0]   cur_pid;
  logic [ptc_pkg::VALUE_W-1:0] cur_val;
  logic [ptc_pkg::TICK_W-1:0]  cur_now;

  // Scan results.
  logic                        hit;
  logic [IW-1:0]               hit_idx;
  logic [ptc_pkg::TICK_W-1:0]  hit_stamp;
  logic [ptc_pkg::VALUE_W-1:0] hit_value;
  logic                        free_any;
  logic [IW-1:0]               free_idx;
  logic                        old_any;
  logic [IW-1:0]               old_idx;
  logic [ptc_pkg::TICK_W-1:0]  old_stamp;

  ptc_pkg::entry_t             rd_data;
  ptc_pkg::entry_t             wdata;
  logic                        we;
  logic [IW-1:0]               waddr;
  logic [IW-1:0]               raddr;

  logic                        accept;
  logic                        rd_match;
  logic                        rd_free;
  logic                        rd_older;
  logic                        issuing;
  logic [ptc_pkg::TICK_W-1:0]  left;
  logic                        expired;
  logic                        full;
  logic [CW-1:0]               count_next;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign issuing = (state == ST_SCAN) && (iss_cnt < ISSUE_END);
  assign raddr   = iss_cnt[IW-1:0];

  assign rd_match = rd_data.valid && (rd_data.key == cur_pid);
  assign rd_free  = !rd_data.valid;
  assign rd_older = rd_data.valid &&
                    (!old_any || ptc_pkg::tick_before(rd_data.stamp, old_stamp));

  // The entry is expired once stamp + ttl lies before the current tick.
  assign left    = hit_stamp + ptc_pkg::TICK_W'(ttl) - cur_now;
  assign expired = left[ptc_pkg::TICK_W-1];
  assign full    = (count >= FULL_CNT);

  ptc_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    we         = 1'b0;
    waddr      = clr_idx;
    wdata      = '0;
    count_next = count;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_FINISH: begin
        if (cur_op == OP_LOOKUP) begin
          if (hit && expired) begin
            we         = 1'b1;
            waddr      = hit_idx;
            count_next = count - CW'(1);
          end
        end else begin
          we          = 1'b1;
          wdata.valid = 1'b1;
          wdata.key   = cur_pid;
          wdata.value = cur_val;
          wdata.stamp = cur_now;
          priority if (hit) begin
            waddr = hit_idx;
          end else if (full) begin
            // Full table: the oldest slot is freed and is then the only free one.
            waddr = old_idx;
          end else begin
            waddr      = free_idx;
            count_next = count + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
      ttl     <= ptc_pkg::TTL_RESET;
      rd_vld  <= 1'b0;
      iss_cnt <= '0;
    end else begin
      if (ttl_wr_en) begin
        ttl <= ttl_wr_data;
      end
      done   <= 1'b0;
      rd_vld <= issuing;
      rd_idx <= raddr;
      if (issuing) begin
        iss_cnt <= iss_cnt + (IW + 1)'(1);
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_op   <= operation;
            cur_pid  <= pid;
            cur_val  <= value_in;
            cur_now  <= now;
            hit      <= 1'b0;
            free_any <= 1'b0;
            old_any  <= 1'b0;
            iss_cnt  <= '0;
            if (pid == '0) begin
              done        <= 1'b1;
              found       <= 1'b0;
              value_out   <= '0;
              entry_count <= ptc_pkg::COUNT_OUT_W'(count);
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld) begin
            if (rd_match) begin
              hit       <= 1'b1;
              hit_idx   <= rd_idx;
              hit_stamp <= rd_data.stamp;
              hit_value <= rd_data.value;
            end
            if (rd_free && !free_any) begin
              free_any <= 1'b1;
              free_idx <= rd_idx;
            end
            if (rd_older) begin
              old_any   <= 1'b1;
              old_idx   <= rd_idx;
              old_stamp <= rd_data.stamp;
            end
            if (rd_idx == LAST_IDX) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          state       <= ST_IDLE;
          done        <= 1'b1;
          count       <= count_next;
          entry_count <= ptc_pkg::COUNT_OUT_W'(count_next);
          if (cur_op == OP_LOOKUP && hit && !expired) begin
            found     <= 1'b1;
            value_out <= hit_value;
          end else begin
            found     <= (cur_op == OP_STORE) && hit;
            value_out <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("valid entry count exceeds table size");

  a_nonzero_pid_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && pid != '0) |=> (busy && !done))
    else $error("command with nonzero pid did not start a scan");

  a_miss_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (value_out == '0))
    else $error("miss returned a nonzero value");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("table written outside clear or finish");

  a_store_keeps_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && cur_op == OP_STORE) |=> (count != '0))
    else $error("store left the table empty");
`endif

endmodule

`default_nettype wire
